FILE: src/at_modem_receive_parser_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the AT modem receive parser checker.
// ----------------------------------------------------------------------------
`ifndef AT_MODEM_RECEIVE_PARSER_TOP_ASSERT_SVH
`define AT_MODEM_RECEIVE_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AMRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amrp checker: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define AMRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amrp checker: next-cycle property failed");

`endif

FILE: src/amrp_pkg.sv
// ----------------------------------------------------------------------------
// amrp_pkg
// Shared types and constants of the AT modem receive parser.
// ----------------------------------------------------------------------------
package amrp_pkg;

  localparam int SIZE_W = 11;

  // Item modes.
  localparam logic [1:0] MODE_BYTE      = 2'd0;
  localparam logic [1:0] MODE_LINK_OPEN = 2'd1;
  localparam logic [1:0] MODE_CLR_REPLY = 2'd2;
  localparam logic [1:0] MODE_CLR_SIZE  = 2'd3;

  // Reply status codes.
  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_OK    = 2'd1;
  localparam logic [1:0] REPLY_ERROR = 2'd2;

  // Characters the parser looks for.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              payload_valid;
    logic              payload_last;
    logic [SIZE_W-1:0] payload_size;
    logic              line_ready;
    logic [1:0]        reply_status;
    logic              connected;
    logic              link_closed;
    logic              frame_start;
    logic              length_error;
  } res_t;

endpackage

FILE: src/amrp_if.sv
// ----------------------------------------------------------------------------
// amrp_item_if / amrp_res_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface amrp_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface amrp_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        payload_last;
  logic [10:0] payload_size;
  logic        line_ready;
  logic [1:0]  reply_status;
  logic        connected;
  logic        link_closed;
  logic        frame_start;
  logic        length_error;

  modport source (output valid, payload_byte, payload_valid, payload_last, payload_size,
                  line_ready, reply_status, connected, link_closed, frame_start,
                  length_error, input ready);
  modport sink (input valid, payload_byte, payload_valid, payload_last, payload_size,
                line_ready, reply_status, connected, link_closed, frame_start,
                length_error, output ready);
endinterface

FILE: src/at_modem_receive_parser_top.sv
// ----------------------------------------------------------------------------
// at_modem_receive_parser_top
// Receive parser for an AT modem link: reply lines, +IPD frames, CLOSED.
//
//   channel  | dir | word contents
//   ---------+-----+----------------------------------------------------------
//   item     | in  | mode, rx_byte
//   result   | out | payload byte/valid/last, size, line, reply, link, pulses
//
// One word per cycle sustained while the sink takes every result word; an
// accepted item word sits in the input register and is written into the
// result register once that register is free, from where the sink can take
// its result word. The whole parser update for one word fits between them.
// Reset (rst, synchronous) clears all parser state and the valid flags of both registers.
// A stalled result holds; input words keep flowing while the result register
// is free or being taken in the same cycle.
// ----------------------------------------------------------------------------
module at_modem_receive_parser_top
  import amrp_pkg::*;
#(
  parameter int LINE_CAPACITY = 128,
  parameter int MAX_PAYLOAD   = 1024
) (
  input  logic       clk,
  input  logic       rst,
  amrp_item_if.sink  item,
  amrp_res_if.source result
);

  logic  fire;
  logic  held_valid;
  logic  out_free;
  item_t held;
  res_t  res;

  amrp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .fire       (fire),
    .held_valid (held_valid),
    .held       (held)
  );

  amrp_core #(
    .LINE_CAPACITY (LINE_CAPACITY),
    .MAX_PAYLOAD   (MAX_PAYLOAD)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held       (held),
    .out_free   (out_free),
    .fire       (fire),
    .res        (res)
  );

  amrp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .res      (res),
    .out_free (out_free),
    .result   (result)
  );

endmodule

FILE: src/amrp_in_stage.sv
// ----------------------------------------------------------------------------
// amrp_in_stage
// Input register: holds one accepted word until the core consumes it.
// ----------------------------------------------------------------------------
module amrp_in_stage
  import amrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  amrp_item_if.sink    item,
  input  logic         fire,
  output logic         held_valid,
  output item_t        held
);

  logic accept;

  assign item.ready = !held_valid || fire;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (fire) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held.mode    <= item.mode;
      held.rx_byte <= item.rx_byte;
    end
  end

endmodule

FILE: src/amrp_core.sv
// ----------------------------------------------------------------------------
// amrp_core
// Parser state and the combinational update for one word.
// ----------------------------------------------------------------------------
module amrp_core
  import amrp_pkg::*;
#(
  parameter int LINE_CAPACITY = 128,
  parameter int MAX_PAYLOAD   = 1024
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  held_valid,
  input  item_t held,
  input  logic  out_free,
  output logic  fire,
  output res_t  res
);

  localparam int LC_W  = $clog2(LINE_CAPACITY + 1);
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int ACC_W = LEN_W + 4;

  localparam logic [1:0] PH_REPLY   = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [39:0]      recent_bytes, recent_bytes_next;
  logic [LC_W-1:0]  line_count, line_count_next;
  logic             line_flag, line_flag_next;
  logic [1:0]       reply_latch, reply_latch_next;
  logic             link_open, link_open_next;
  logic [1:0]       phase, phase_next;
  logic [LEN_W-1:0] length_accum, length_accum_next;
  logic             digits_done, digits_done_next;
  logic [LEN_W-1:0] payload_count, payload_count_next;
  logic [LEN_W-1:0] size_latch, size_latch_next;

  logic [7:0]       b;
  logic [ACC_W-1:0] acc_wide;
  logic [LEN_W:0]   count_inc;
  logic             ipd, cls, okm, erm;
  logic             pvalid, plast, closed, fstart, lerr;

  assign fire = held_valid && out_free;
  assign b    = held.rx_byte;

  // Length times ten plus the new digit, wide enough not to wrap.
  assign acc_wide = (ACC_W'(length_accum) << 3) + (ACC_W'(length_accum) << 1)
                  + ACC_W'(b[3:0]);
  assign count_inc = {1'b0, payload_count} + 1'b1;

  assign ipd = link_open && b == CH_COMMA && recent_bytes[7:0] == CH_D &&
               recent_bytes[15:8] == CH_P && recent_bytes[23:16] == CH_I &&
               recent_bytes[31:24] == CH_PLUS;
  assign cls = link_open && b == CH_D && recent_bytes[7:0] == CH_E &&
               recent_bytes[15:8] == CH_S && recent_bytes[23:16] == CH_O &&
               recent_bytes[31:24] == CH_L && recent_bytes[39:32] == CH_C;
  assign okm = b == CH_K && recent_bytes[7:0] == CH_O;
  assign erm = b == CH_R && recent_bytes[7:0] == CH_O && recent_bytes[15:8] == CH_R &&
               recent_bytes[23:16] == CH_R && recent_bytes[31:24] == CH_E;

  always_comb begin
    recent_bytes_next  = recent_bytes;
    line_count_next    = line_count;
    line_flag_next     = line_flag;
    reply_latch_next   = reply_latch;
    link_open_next     = link_open;
    phase_next         = phase;
    length_accum_next  = length_accum;
    digits_done_next   = digits_done;
    payload_count_next = payload_count;
    size_latch_next    = size_latch;
    pvalid = 1'b0;
    plast  = 1'b0;
    closed = 1'b0;
    fstart = 1'b0;
    lerr   = 1'b0;

    case (held.mode)
      MODE_LINK_OPEN: begin
        link_open_next = 1'b1;
      end
      MODE_CLR_REPLY: begin
        recent_bytes_next = '0;
        line_count_next   = '0;
        line_flag_next    = 1'b0;
        reply_latch_next  = REPLY_NONE;
      end
      MODE_CLR_SIZE: begin
        if (phase != PH_PAYLOAD) begin
          size_latch_next = '0;
        end
      end
      default: begin
        case (phase)
          PH_HEADER: begin
            if (b == CH_COLON) begin
              size_latch_next    = length_accum;
              payload_count_next = '0;
              if (length_accum == '0) begin
                // An empty frame ends right at the colon.
                phase_next        = PH_REPLY;
                recent_bytes_next = '0;
                line_count_next   = '0;
                line_flag_next    = 1'b0;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end else if (!digits_done && (b inside {[CH_0:CH_9]})) begin
              if (acc_wide > ACC_W'(MAX_PAYLOAD)) begin
                length_accum_next = LEN_W'(MAX_PAYLOAD);
                lerr = 1'b1;
              end else begin
                length_accum_next = acc_wide[LEN_W-1:0];
              end
            end else begin
              digits_done_next = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            pvalid = 1'b1;
            payload_count_next = count_inc[LEN_W-1:0];
            if (count_inc >= {1'b0, size_latch}) begin
              plast             = 1'b1;
              phase_next        = PH_REPLY;
              recent_bytes_next = '0;
              line_count_next   = '0;
              line_flag_next    = 1'b0;
            end
          end
          default: begin
            if (line_count >= LC_W'(LINE_CAPACITY)) begin
              // Line is full: the byte is dropped and not matched.
              line_flag_next = 1'b1;
            end else begin
              line_count_next   = line_count + 1'b1;
              recent_bytes_next = {recent_bytes[31:0], b};
              if (reply_latch == REPLY_NONE) begin
                if (okm) begin
                  reply_latch_next = REPLY_OK;
                end else if (erm) begin
                  reply_latch_next = REPLY_ERROR;
                end
              end
              if (b == CH_NUL || b == CH_LF) begin
                line_flag_next = 1'b1;
              end
              if (ipd) begin
                fstart            = 1'b1;
                phase_next        = PH_HEADER;
                length_accum_next = '0;
                digits_done_next  = 1'b0;
                recent_bytes_next = '0;
                line_count_next   = '0;
                line_flag_next    = 1'b0;
              end
              if (cls) begin
                closed            = 1'b1;
                link_open_next    = 1'b0;
                recent_bytes_next = '0;
                line_count_next   = '0;
                line_flag_next    = 1'b0;
              end
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes  <= '0;
      line_count    <= '0;
      line_flag     <= 1'b0;
      reply_latch   <= REPLY_NONE;
      link_open     <= 1'b0;
      phase         <= PH_REPLY;
      length_accum  <= '0;
      digits_done   <= 1'b0;
      payload_count <= '0;
      size_latch    <= '0;
    end else if (fire) begin
      recent_bytes  <= recent_bytes_next;
      line_count    <= line_count_next;
      line_flag     <= line_flag_next;
      reply_latch   <= reply_latch_next;
      link_open     <= link_open_next;
      phase         <= phase_next;
      length_accum  <= length_accum_next;
      digits_done   <= digits_done_next;
      payload_count <= payload_count_next;
      size_latch    <= size_latch_next;
    end
  end

  always_comb begin
    res.payload_byte  = pvalid ? b : 8'd0;
    res.payload_valid = pvalid;
    res.payload_last  = plast;
    res.payload_size  = SIZE_W'(size_latch_next);
    res.line_ready    = line_flag_next;
    res.reply_status  = reply_latch_next;
    res.connected     = link_open_next;
    res.link_closed   = closed;
    res.frame_start   = fstart;
    res.length_error  = lerr;
  end

endmodule

FILE: src/amrp_out_stage.sv
// ----------------------------------------------------------------------------
// amrp_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module amrp_out_stage
  import amrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  res_t        res,
  output logic        out_free,
  amrp_res_if.source  result
);

  logic res_valid;
  res_t res_q;

  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign result.valid         = res_valid;
  assign result.payload_byte  = res_q.payload_byte;
  assign result.payload_valid = res_q.payload_valid;
  assign result.payload_last  = res_q.payload_last;
  assign result.payload_size  = res_q.payload_size;
  assign result.line_ready    = res_q.line_ready;
  assign result.reply_status  = res_q.reply_status;
  assign result.connected     = res_q.connected;
  assign result.link_closed   = res_q.link_closed;
  assign result.frame_start   = res_q.frame_start;
  assign result.length_error  = res_q.length_error;

endmodule

FILE: src/amrp_checker.sv
// ----------------------------------------------------------------------------
// amrp_checker
// Port-level checks of the receive parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "at_modem_receive_parser_top_assert.svh"

module amrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  payload_byte,
  input logic        payload_valid,
  input logic        payload_last,
  input logic        line_ready,
  input logic        connected,
  input logic        link_closed,
  input logic        frame_start
);

  // A stalled result word must stay valid and keep its payload byte and last mark.
  `AMRP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(payload_byte) && $stable(payload_last))

  // The last-byte mark only rides on a payload byte.
  `AMRP_ASSERT_NOW(a_last_is_payload, out_valid && payload_last, payload_valid)

  // Outside payload the byte field is zero.
  `AMRP_ASSERT_NOW(a_idle_byte_zero, out_valid && !payload_valid, payload_byte == 8'd0)

  // A frame header needs an open link and restarts the line.
  `AMRP_ASSERT_NOW(a_frame_start_link, out_valid && frame_start,
    connected && !line_ready && !link_closed)

  // CLOSED drops the link at once.
  `AMRP_ASSERT_NOW(a_closed_drops, out_valid && link_closed, !connected && !payload_valid)

endmodule

bind at_modem_receive_parser_top amrp_checker u_amrp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .payload_byte  (result.payload_byte),
  .payload_valid (result.payload_valid),
  .payload_last  (result.payload_last),
  .line_ready    (result.line_ready),
  .connected     (result.connected),
  .link_closed   (result.link_closed),
  .frame_start   (result.frame_start)
);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AT modem receive parser. A scoreboard class
// tracks the parser state in software and predicts one result word for
// every accepted item word. Stimulus runs a short directed sequence, then
// random traffic made mostly of well-formed +IPD frames, reply lines and
// CLOSED notices, mixed with noise. The sender idles in bursts. The receiver
// stalls on its own patterns and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import amrp_pkg::*;

  localparam int LINE_CAP     = 128;
  localparam int MAX_PAY      = 64;
  localparam int ITEM_TARGET  = 640;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum logic [1:0] {PH_REPLY, PH_HEADER, PH_PAYLOAD} parse_phase_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  class parser_scoreboard;
    int           errors;
    int           accepted;
    int           checked;
    res_t         expected_q[$];
    logic [39:0]  recent;
    int           line_count;
    bit           line_flag;
    logic [1:0]   reply;
    bit           link_up;
    parse_phase_t phase;
    int           length_accum;
    bit           digits_done;
    int           payload_count;
    logic [SIZE_W-1:0] size_latch;

    function new();
      clear_line();
      reply         = REPLY_NONE;
      link_up       = 1'b0;
      phase         = PH_REPLY;
      length_accum  = 0;
      digits_done   = 1'b0;
      payload_count = 0;
      size_latch    = '0;
      errors        = 0;
      accepted      = 0;
      checked       = 0;
    endfunction

    function void clear_line();
      recent     = '0;
      line_count = 0;
      line_flag  = 1'b0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("MISMATCH at %0t: %s", $time, msg);
      end
    endfunction

    // Applies one accepted item word to the tracked state and queues the
    // result word the parser must produce for it.
    function void note_item(item_t it);
      res_t       r;
      logic [7:0] b;
      int         v;
      bit         ipd, cls, okm, erm;
      r = '0;
      b = it.rx_byte;
      if (it.mode == MODE_LINK_OPEN) begin
        link_up = 1'b1;
      end else if (it.mode == MODE_CLR_REPLY) begin
        clear_line();
        reply = REPLY_NONE;
      end else if (it.mode == MODE_CLR_SIZE) begin
        if (phase != PH_PAYLOAD) size_latch = '0;
      end else if (phase == PH_HEADER) begin
        if (b == CH_COLON) begin
          size_latch    = length_accum[SIZE_W-1:0];
          payload_count = 0;
          if (length_accum == 0) begin
            phase = PH_REPLY;
            clear_line();
          end else begin
            phase = PH_PAYLOAD;
          end
        end else if (!digits_done && b >= CH_0 && b <= CH_9) begin
          v = length_accum * 10 + int'(b - CH_0);
          if (v > MAX_PAY) begin
            v = MAX_PAY;
            r.length_error = 1'b1;
          end
          length_accum = v;
        end else begin
          digits_done = 1'b1;
        end
      end else if (phase == PH_PAYLOAD) begin
        r.payload_byte  = b;
        r.payload_valid = 1'b1;
        payload_count++;
        if (payload_count >= size_latch) begin
          r.payload_last = 1'b1;
          phase = PH_REPLY;
          clear_line();
        end
      end else if (line_count >= LINE_CAP) begin
        // A full line drops the byte without matching it.
        line_flag = 1'b1;
      end else begin
        ipd = link_up && b == CH_COMMA && recent[7:0] == CH_D && recent[15:8] == CH_P &&
              recent[23:16] == CH_I && recent[31:24] == CH_PLUS;
        cls = link_up && b == CH_D && recent[7:0] == CH_E && recent[15:8] == CH_S &&
              recent[23:16] == CH_O && recent[31:24] == CH_L && recent[39:32] == CH_C;
        okm = b == CH_K && recent[7:0] == CH_O;
        erm = b == CH_R && recent[7:0] == CH_O && recent[15:8] == CH_R &&
              recent[23:16] == CH_R && recent[31:24] == CH_E;
        line_count++;
        recent = {recent[31:0], b};
        if (reply == REPLY_NONE) begin
          if (okm) reply = REPLY_OK;
          else if (erm) reply = REPLY_ERROR;
        end
        if (b == CH_NUL || b == CH_LF) line_flag = 1'b1;
        if (ipd) begin
          r.frame_start = 1'b1;
          phase         = PH_HEADER;
          length_accum  = 0;
          digits_done   = 1'b0;
          clear_line();
        end
        if (cls) begin
          r.link_closed = 1'b1;
          link_up       = 1'b0;
          clear_line();
        end
      end
      r.payload_size = size_latch;
      r.line_ready   = line_flag;
      r.reply_status = reply;
      r.connected    = link_up;
      expected_q.push_back(r);
      accepted++;
    endfunction

    function void compare_field(string name, logic [SIZE_W-1:0] got, logic [SIZE_W-1:0] want);
      if (got !== want) begin
        report($sformatf("word %0d field %s: got %0h, expected %0h", checked, name, got, want));
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        report("result word arrived with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      compare_field("payload_byte", got.payload_byte, want.payload_byte);
      compare_field("payload_valid", got.payload_valid, want.payload_valid);
      compare_field("payload_last", got.payload_last, want.payload_last);
      compare_field("payload_size", got.payload_size, want.payload_size);
      compare_field("line_ready", got.line_ready, want.line_ready);
      compare_field("reply_status", got.reply_status, want.reply_status);
      compare_field("connected", got.connected, want.connected);
      compare_field("link_closed", got.link_closed, want.link_closed);
      compare_field("frame_start", got.frame_start, want.frame_start);
      compare_field("length_error", got.length_error, want.length_error);
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   burst_left = 0;
  logic [1:0] mode_events[3] = '{MODE_LINK_OPEN, MODE_CLR_REPLY, MODE_CLR_SIZE};

  amrp_item_if item_ch();
  amrp_res_if  res_ch();

  parser_scoreboard sb = new();

  at_modem_receive_parser_top #(
    .LINE_CAPACITY(LINE_CAP),
    .MAX_PAYLOAD  (MAX_PAY)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(res_ch)
  );

  always #5 clk = ~clk;

  // Generous watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_result('{payload_byte: res_ch.payload_byte, payload_valid: res_ch.payload_valid,
                        payload_last: res_ch.payload_last, payload_size: res_ch.payload_size,
                        line_ready: res_ch.line_ready, reply_status: res_ch.reply_status,
                        connected: res_ch.connected, link_closed: res_ch.link_closed,
                        frame_start: res_ch.frame_start, length_error: res_ch.length_error});
    end
  end

  // Offers one item word and waits until it is accepted. The sender works
  // in bursts, with a random gap before each new burst.
  task automatic send(input logic [1:0] m, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        item_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    item_ch.valid   <= 1'b1;
    item_ch.mode    <= m;
    item_ch.rx_byte <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item('{mode: m, rx_byte: b});
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(MODE_BYTE, s[i]);
  endtask

  // Receiver stalls follow patterns of their own; once, it holds off long
  // enough for the parser to fill up and stall its input.
  initial begin : receiver
    stall_style_t style;
    int style_left;
    int hold_left;
    bit held;
    style      = STALL_NONE;
    style_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.accepted >= 150) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        style      = stall_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 120);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (style)
          STALL_NONE:  res_ch.ready <= 1'b1;
          STALL_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
          STALL_HEAVY: res_ch.ready <= ($urandom_range(0, 2) == 0);
          default:     res_ch.ready <= ((cycles % 7) < 4);
        endcase
      end
    end
  end

  initial begin
    int    pick;
    int    len;
    int    n;
    int    big_frames;
    int    long_lines;
    string digits;
    big_frames      = 0;
    long_lines      = 0;
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.mode    = MODE_BYTE;
    item_ch.rx_byte = 8'h00;
    res_ch.ready    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: replies, line ends, link events, a short frame, an
    // empty frame and the close notice.
    send_text("OK\n");
    send(MODE_CLR_REPLY, 8'hFF);
    send_text("ERROR");
    send(MODE_BYTE, CH_NUL);
    send(MODE_LINK_OPEN, 8'h00);
    send(MODE_LINK_OPEN, 8'h55);
    send_text("+IPD,2:");
    send(MODE_CLR_SIZE, 8'hAA);      // ignored while the payload runs
    send(MODE_BYTE, CH_COLON);
    send(MODE_BYTE, 8'hFF);
    send(MODE_CLR_SIZE, 8'h00);
    send_text("+IPD,0:");
    send_text("CLOSED");

    while (sb.accepted < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        if ($urandom_range(0, 2) == 0) send(MODE_CLR_REPLY, 8'($urandom_range(0, 255)));
        if (!sb.link_up && $urandom_range(0, 4) != 0) begin
          send(MODE_LINK_OPEN, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 2) == 0) send_text("\r\n");
        if ($urandom_range(0, 9) == 0) send_text("+IP");
        send_text("+IPD,");
        n = $urandom_range(0, 99);
        if (n < 6) begin
          len = 0;
        end else if (n < 9 && big_frames < 2) begin
          // Over-long length: saturates, so the frame carries MAX_PAY bytes.
          len = $urandom_range(MAX_PAY + 1, 99999);
          big_frames++;
        end else if (n < 13) begin
          len = $urandom_range(40, 200);
        end else begin
          len = $urandom_range(1, 24);
        end
        digits = $sformatf("%0d", len);
        if ($urandom_range(0, 7) == 0) digits = {"0", digits};
        for (int i = 0; i < digits.len(); i++) begin
          if ($urandom_range(0, 11) == 0) begin
            send(mode_events[2'($urandom_range(0, 2))], 8'($urandom_range(0, 255)));
          end
          send(MODE_BYTE, digits[i]);
        end
        // Digits after the first non-digit are ignored up to the colon.
        if ($urandom_range(0, 3) == 0) begin
          send(MODE_BYTE, CH_COMMA);
          send_text($sformatf("%0d", $urandom_range(0, 999)));
        end
        send(MODE_BYTE, CH_COLON);
        while (sb.phase == PH_PAYLOAD) begin
          if ($urandom_range(0, 29) == 0) send(MODE_CLR_SIZE, 8'($urandom_range(0, 255)));
          else send(MODE_BYTE, 8'($urandom_range(0, 255)));
        end
      end else if (pick < 46) begin
        n = $urandom_range(0, 8);
        repeat (n) send(MODE_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
        case ($urandom_range(0, 3))
          0:       send_text("OK");
          1:       send_text("ERROR");
          2:       send_text("ERR");
          default: ;
        endcase
        if ($urandom_range(0, 4) == 0) send(MODE_BYTE, CH_NUL);
        else send_text("\r\n");
      end else if (pick < 54) begin
        send(MODE_CLR_REPLY, 8'($urandom_range(0, 255)));
      end else if (pick < 60) begin
        send(MODE_LINK_OPEN, 8'($urandom_range(0, 255)));
      end else if (pick < 66) begin
        send(MODE_CLR_SIZE, 8'($urandom_range(0, 255)));
      end else if (pick < 74) begin
        if ($urandom_range(0, 1) == 0) send_text("0,");
        if ($urandom_range(0, 4) == 0) begin
          send_text("CLOSE");
          send(MODE_BYTE, 8'($urandom_range(8'h41, 8'h5A)));
        end else begin
          send_text("CLOSED");
        end
        send_text("\r\n");
      end else if (pick < 97 || long_lines >= 4) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            send(mode_events[2'($urandom_range(0, 2))], 8'($urandom_range(0, 255)));
          end else begin
            send(MODE_BYTE, 8'($urandom_range(0, 255)));
          end
        end
      end else begin
        // A line longer than the buffer; the reply at its end gets dropped.
        long_lines++;
        n = $urandom_range(LINE_CAP + 2, LINE_CAP + 12);
        repeat (n) send(MODE_BYTE, 8'($urandom_range(CH_0, 8'h5A)));
        send_text("OK\r\n");
      end
    end

    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
